// ===== rtl/urc_pkg.sv =====
// Shared types, constants and helpers for the ultrasonic ranger with
// least-squares calibration. No dependencies.
package urc_pkg;

   // Raw distance limit, 1/256 cm
   localparam logic [19:0] RAW_MAX = 20'hFFFFF;
   // Half sound speed after reset, Q0.16 (0.017 cm/us)
   localparam logic [15:0] HSS_RESET = 16'd1114;
   // 0.3937 in Q0.16
   localparam logic [63:0] INCH_Q16 = 64'd25802;

   localparam logic signed [23:0] S24_MAX   = 24'sh7FFFFF;
   localparam logic signed [23:0] S24_MIN   = 24'sh800000;
   localparam logic signed [23:0] SLOPE_ONE = 24'sh010000;

   // Item selector codes; the spare code behaves as a measure
   localparam logic [1:0] FUNC_MEASURE = 2'd0;
   localparam logic [1:0] FUNC_CAL     = 2'd1;
   localparam logic [1:0] FUNC_CLEAR   = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_MEASURED = 3'd0;
   localparam logic [2:0] ST_FIT      = 3'd1;
   localparam logic [2:0] ST_DEGEN    = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_CLEARED  = 3'd4;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   // Command to the shared shift/add unit
   typedef struct packed {
      logic        start;
      alu_op_type  op;
      logic [63:0] opa;    // multiplicand, or dividend bits left aligned
      logic [63:0] opb;    // multiplier, or divisor
      logic [63:0] rinit;  // initial partial remainder (divide)
      logic [6:0]  steps;  // quotient bits to produce (divide)
   } alu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } alu_rsp_type;

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      logic signed [23:0] r;
      if (v > 64'sd8388607) begin
         r = S24_MAX;
      end else if (v < -64'sd8388608) begin
         r = S24_MIN;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/urc_alu.sv =====
// Shared iterative arithmetic unit: shift-add multiply and restoring divide
// over one 65-bit adder. Depends on urc_pkg.
module urc_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  urc_pkg::alu_cmd_type cmd,
   output urc_pkg::alu_rsp_type rsp
);

   typedef enum logic {
      ALU_IDLE,
      ALU_RUN
   } alu_state_type;

   alu_state_type       state_ff;
   urc_pkg::alu_op_type op_ff;
   logic [63:0]         acc_ff;
   logic [63:0]         x_ff;
   logic [63:0]         y_ff;
   logic [6:0]          cnt_ff;
   logic                done_ff;

   logic [64:0] add_a;
   logic [64:0] add_b;
   logic [64:0] r2;
   logic [65:0] sum;
   logic        cin;
   logic        ge;
   logic        finished;

   // Select adder operands for a multiply or a divide step
   always_comb begin
      r2 = {acc_ff, x_ff[63]};
      if (op_ff == urc_pkg::ALU_MUL) begin
         add_a    = {1'b0, acc_ff};
         add_b    = {1'b0, x_ff};
         cin      = 1'b0;
         finished = (y_ff == '0);
      end else begin
         add_a    = r2;
         add_b    = ~{1'b0, y_ff};
         cin      = 1'b1;
         finished = (cnt_ff == '0);
      end
      sum = {1'b0, add_a} + {1'b0, add_b} + 66'(cin);
      ge  = sum[65];
   end

   // Sequence the steps; one multiplier bit or one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ALU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            ALU_IDLE: begin
               if (cmd.start) begin
                  op_ff    <= cmd.op;
                  acc_ff   <= (cmd.op == urc_pkg::ALU_MUL) ? 64'd0 : cmd.rinit;
                  x_ff     <= cmd.opa;
                  y_ff     <= cmd.opb;
                  cnt_ff   <= cmd.steps;
                  state_ff <= ALU_RUN;
               end
            end
            ALU_RUN: begin
               if (finished) begin
                  done_ff  <= 1'b1;
                  state_ff <= ALU_IDLE;
               end else if (op_ff == urc_pkg::ALU_MUL) begin
                  if (y_ff[0]) begin
                     acc_ff <= sum[63:0];
                  end
                  x_ff <= {x_ff[62:0], 1'b0};
                  y_ff <= {1'b0, y_ff[63:1]};
               end else begin
                  acc_ff <= ge ? sum[63:0] : r2[63:0];
                  x_ff   <= {x_ff[62:0], ge};
                  cnt_ff <= cnt_ff - 7'd1;
               end
            end
            default: state_ff <= ALU_IDLE;
         endcase
      end
   end

   always_comb begin
      rsp.done   = done_ff;
      rsp.result = (op_ff == urc_pkg::ALU_MUL) ? acc_ff : x_ff;
   end

endmodule

// ===== rtl/ultrasonic_range_with_ls_calibration.sv =====
// Top level: ultrasonic ranger with least-squares linear calibration.
// Holds the fit state and the sequencer; depends on urc_pkg and urc_alu.
//
// Usage:
//   Request channel (req_*) carries func, echo_us, known_dist and unit; a
//   transfer happens when req_valid is high and req_stall is low. The block
//   takes one item at a time: req_stall stays high from a transfer until its
//   result has been placed in the output register.
//   Result channel (rsp_*) carries status, distance, point_count, slope and
//   intercept; exactly one result per item, held while rsp_stall is high.
//   The next request may transfer while a result still waits in the output
//   register.
//   Every item runs through one shared 64-bit add/subtract unit that
//   retires one multiplier bit or one quotient bit per cycle. A clear or a
//   store-full item uses only the raw conversion, a measure one or two more
//   multiplies, a refit with two or more points the raw conversion, seven
//   more multiplies, a 25-step and a 64-step divide (fewer when the fit is
//   degenerate or the slope saturates). csr_wr_en writes half_sound_speed;
//   write it only while no item is open. Reset (synchronous) restores
//   half_sound_speed to 0.017 cm/us, empties the calibration store, sets
//   slope to one and intercept to zero, and drops any pending result.
module ultrasonic_range_with_ls_calibration #(
   parameter int MAX_POINTS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [15:0]        req_echo_us,
   input  logic [19:0]        req_known_dist,
   input  logic               req_unit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic signed [23:0] rsp_distance,
   output logic [8:0]         rsp_point_count,
   output logic signed [23:0] rsp_slope,
   output logic signed [23:0] rsp_intercept
);

   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int SXW  = 20 + CW;
   localparam int SXXW = 40 + CW;

   typedef enum logic [4:0] {
      S_IDLE, S_RAW, S_DISPATCH, S_SQ, S_XY, S_NEWPT, S_NSXX, S_SXSX,
      S_NSXY, S_SXSY, S_CHECK, S_DEGPREP, S_DEGDIV, S_QPREP, S_QDIV,
      S_OPREP, S_OMUL, S_OPREP2, S_ODIV, S_MMUL, S_MRND, S_MIPREP,
      S_MIMUL, S_MIRND, S_FINISH
   } state_type;

   state_type                state_ff;
   logic [15:0]              hss_ff;
   logic [1:0]               func_ff;
   logic [19:0]              known_ff;
   logic                     unit_ff;
   logic [19:0]              raw_ff;
   logic [CW-1:0]            count_ff;
   logic [SXW-1:0]           sx_ff;
   logic [SXW-1:0]           sy_ff;
   logic [SXXW-1:0]          sxx_ff;
   logic [SXXW-1:0]          sxy_ff;
   logic signed [23:0]       slope_ff;
   logic signed [23:0]       offset_ff;
   logic signed [63:0]       t_ff;
   logic signed [63:0]       den_ff;
   logic signed [63:0]       num_ff;
   logic                     neg_ff;
   logic [2:0]               status_ff;
   logic signed [23:0]       dist_ff;
   urc_pkg::alu_cmd_type     alu_cmd_ff;
   urc_pkg::alu_rsp_type     alu_rsp;
   logic                     rsp_valid_ff;
   logic [2:0]               rsp_status_ff;
   logic signed [23:0]       rsp_distance_ff;
   logic [8:0]               rsp_point_count_ff;
   logic signed [23:0]       rsp_slope_ff;
   logic signed [23:0]       rsp_intercept_ff;

   logic [63:0]        prod;
   logic signed [63:0] prod_s;
   logic signed [63:0] slope_w;
   logic [63:0]        slope_mag;
   logic [63:0]        t_mag;
   logic [63:0]        n64;
   logic signed [63:0] sy_q;
   logic signed [63:0] q_signed;
   logic signed [63:0] p_rnd;
   logic signed [63:0] c_meas;
   logic signed [63:0] known_raw;
   logic signed [63:0] sy_sx;
   logic [24:0]        v_q;
   logic signed [63:0] v_s;
   logic signed [63:0] slope_q;
   logic [19:0]        raw_sat;
   logic [63:0]        num_hi;
   logic               den_nonpos;
   logic [31:0]        cnt_wide;

   function automatic urc_pkg::alu_cmd_type mul_cmd(input logic [63:0] a,
                                                    input logic [63:0] b);
      urc_pkg::alu_cmd_type c;
      c.start = 1'b1;
      c.op    = urc_pkg::ALU_MUL;
      c.opa   = a;
      c.opb   = b;
      c.rinit = 64'd0;
      c.steps = 7'd0;
      return c;
   endfunction

   function automatic urc_pkg::alu_cmd_type div_cmd(input logic [63:0] rinit,
                                                    input logic [63:0] feed,
                                                    input logic [63:0] den,
                                                    input logic [6:0]  steps);
      urc_pkg::alu_cmd_type c;
      c.start = 1'b1;
      c.op    = urc_pkg::ALU_DIV;
      c.opa   = feed;
      c.opb   = den;
      c.rinit = rinit;
      c.steps = steps;
      return c;
   endfunction

   urc_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd_ff),
      .rsp   (alu_rsp)
   );

   // Operand shaping around the shared unit
   always_comb begin
      prod       = alu_rsp.result;
      prod_s     = $signed(prod);
      slope_w    = 64'(slope_ff);
      slope_mag  = slope_ff[23] ? 64'(-slope_w) : 64'(slope_w);
      t_mag      = t_ff[63] ? 64'(-t_ff) : 64'(t_ff);
      n64        = 64'(count_ff);
      sy_q       = $signed(64'(sy_ff) << 16);
      q_signed   = neg_ff ? -prod_s : prod_s;
      p_rnd      = neg_ff ? (64'sd32768 - prod_s) : (prod_s + 64'sd32768);
      c_meas     = (t_ff >>> 16) + 64'(offset_ff);
      known_raw  = $signed(64'(known_ff)) - $signed(64'(raw_ff));
      sy_sx      = $signed(64'(sy_ff)) - $signed(64'(sx_ff));
      v_q        = 25'(({1'b0, prod[24:0]} + 26'd1) >> 1);
      v_s        = $signed(64'(v_q));
      slope_q    = neg_ff ? -v_s : v_s;
      raw_sat    = (prod[63:28] != '0) ? urc_pkg::RAW_MAX : prod[27:8];
      num_hi     = 64'(num_ff) >> 8;
      den_nonpos = den_ff[63] || (den_ff == 64'sd0);
      cnt_wide   = 32'(count_ff);
   end

   // Sequencer, fit state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         hss_ff           <= urc_pkg::HSS_RESET;
         count_ff         <= '0;
         sx_ff            <= '0;
         sy_ff            <= '0;
         sxx_ff           <= '0;
         sxy_ff           <= '0;
         slope_ff         <= urc_pkg::SLOPE_ONE;
         offset_ff        <= '0;
         alu_cmd_ff.start <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // Drop the start pulse in the cycle after a command issues
         if (alu_cmd_ff.start) begin
            alu_cmd_ff.start <= 1'b0;
         end
         if (csr_wr_en) begin
            hss_ff <= csr_wr_data;
         end
         // Drop the result once transferred, unless a new one loads now
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  func_ff    <= req_func;
                  known_ff   <= req_known_dist;
                  unit_ff    <= req_unit;
                  dist_ff    <= '0;
                  alu_cmd_ff <= mul_cmd(64'(req_echo_us), 64'(hss_ff));
                  state_ff   <= S_RAW;
               end
            end
            S_RAW: begin
               if (alu_rsp.done) begin
                  raw_ff   <= raw_sat;
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               unique case (func_ff)
                  urc_pkg::FUNC_CLEAR: begin
                     count_ff  <= '0;
                     sx_ff     <= '0;
                     sy_ff     <= '0;
                     sxx_ff    <= '0;
                     sxy_ff    <= '0;
                     slope_ff  <= urc_pkg::SLOPE_ONE;
                     offset_ff <= '0;
                     status_ff <= urc_pkg::ST_CLEARED;
                     state_ff  <= S_FINISH;
                  end
                  urc_pkg::FUNC_CAL: begin
                     if (count_ff >= CW'(MAX_POINTS)) begin
                        status_ff <= urc_pkg::ST_FULL;
                        state_ff  <= S_FINISH;
                     end else begin
                        alu_cmd_ff <= mul_cmd(64'(raw_ff), 64'(raw_ff));
                        state_ff   <= S_SQ;
                     end
                  end
                  default: begin
                     neg_ff     <= slope_ff[23];
                     alu_cmd_ff <= mul_cmd(64'(raw_ff), slope_mag);
                     state_ff   <= S_MMUL;
                  end
               endcase
            end
            // Accumulate the new point
            S_SQ: begin
               if (alu_rsp.done) begin
                  sxx_ff     <= sxx_ff + prod[SXXW-1:0];
                  alu_cmd_ff <= mul_cmd(64'(raw_ff), 64'(known_ff));
                  state_ff   <= S_XY;
               end
            end
            S_XY: begin
               if (alu_rsp.done) begin
                  sxy_ff   <= sxy_ff + prod[SXXW-1:0];
                  sx_ff    <= sx_ff + SXW'(raw_ff);
                  sy_ff    <= sy_ff + SXW'(known_ff);
                  count_ff <= count_ff + CW'(1);
                  state_ff <= S_NEWPT;
               end
            end
            S_NEWPT: begin
               if (count_ff == CW'(1)) begin
                  slope_ff  <= urc_pkg::SLOPE_ONE;
                  offset_ff <= urc_pkg::sat24(known_raw);
                  status_ff <= urc_pkg::ST_FIT;
                  state_ff  <= S_FINISH;
               end else begin
                  alu_cmd_ff <= mul_cmd(64'(sxx_ff), n64);
                  state_ff   <= S_NSXX;
               end
            end
            // Denominator n*Sxx - Sx^2
            S_NSXX: begin
               if (alu_rsp.done) begin
                  t_ff       <= prod_s;
                  alu_cmd_ff <= mul_cmd(64'(sx_ff), 64'(sx_ff));
                  state_ff   <= S_SXSX;
               end
            end
            S_SXSX: begin
               if (alu_rsp.done) begin
                  den_ff     <= t_ff - prod_s;
                  alu_cmd_ff <= mul_cmd(64'(sxy_ff), n64);
                  state_ff   <= S_NSXY;
               end
            end
            // Numerator n*Sxy - Sx*Sy
            S_NSXY: begin
               if (alu_rsp.done) begin
                  t_ff       <= prod_s;
                  alu_cmd_ff <= mul_cmd(64'(sx_ff), 64'(sy_ff));
                  state_ff   <= S_SXSY;
               end
            end
            S_SXSY: begin
               if (alu_rsp.done) begin
                  num_ff   <= t_ff - prod_s;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (den_nonpos) begin
                  slope_ff <= urc_pkg::SLOPE_ONE;
                  t_ff     <= sy_sx;
                  state_ff <= S_DEGPREP;
               end else begin
                  neg_ff   <= num_ff[63];
                  num_ff   <= num_ff[63] ? -num_ff : num_ff;
                  state_ff <= S_QPREP;
               end
            end
            // All raws equal: intercept is the rounded mean difference
            S_DEGPREP: begin
               neg_ff     <= t_ff[63];
               alu_cmd_ff <= div_cmd(64'd0, t_mag + (n64 >> 1), n64, 7'd64);
               state_ff   <= S_DEGDIV;
            end
            S_DEGDIV: begin
               if (alu_rsp.done) begin
                  offset_ff <= urc_pkg::sat24(q_signed);
                  status_ff <= urc_pkg::ST_DEGEN;
                  state_ff  <= S_FINISH;
               end
            end
            // Slope in Q8.16; a quotient of 256 or more saturates
            S_QPREP: begin
               if (num_hi >= 64'(den_ff)) begin
                  slope_ff <= neg_ff ? urc_pkg::S24_MIN : urc_pkg::S24_MAX;
                  state_ff <= S_OPREP;
               end else begin
                  alu_cmd_ff <= div_cmd(num_hi, {num_ff[7:0], 56'd0},
                                        64'(den_ff), 7'd25);
                  state_ff   <= S_QDIV;
               end
            end
            S_QDIV: begin
               if (alu_rsp.done) begin
                  slope_ff <= urc_pkg::sat24(slope_q);
                  state_ff <= S_OPREP;
               end
            end
            // Intercept (Sy*2^16 - slope*Sx) / (n*2^16)
            S_OPREP: begin
               neg_ff     <= slope_ff[23];
               alu_cmd_ff <= mul_cmd(64'(sx_ff), slope_mag);
               state_ff   <= S_OMUL;
            end
            S_OMUL: begin
               if (alu_rsp.done) begin
                  t_ff     <= neg_ff ? (sy_q + prod_s) : (sy_q - prod_s);
                  state_ff <= S_OPREP2;
               end
            end
            S_OPREP2: begin
               neg_ff     <= t_ff[63];
               alu_cmd_ff <= div_cmd(64'd0, t_mag + (n64 << 15), n64 << 16, 7'd64);
               state_ff   <= S_ODIV;
            end
            S_ODIV: begin
               if (alu_rsp.done) begin
                  offset_ff <= urc_pkg::sat24(q_signed);
                  status_ff <= urc_pkg::ST_FIT;
                  state_ff  <= S_FINISH;
               end
            end
            // Measure: slope*raw rounded, plus intercept, then scaled to inches if unit is set
            S_MMUL: begin
               if (alu_rsp.done) begin
                  t_ff     <= p_rnd;
                  state_ff <= S_MRND;
               end
            end
            S_MRND: begin
               if (unit_ff) begin
                  t_ff     <= c_meas;
                  state_ff <= S_MIPREP;
               end else begin
                  dist_ff   <= urc_pkg::sat24(c_meas);
                  status_ff <= urc_pkg::ST_MEASURED;
                  state_ff  <= S_FINISH;
               end
            end
            S_MIPREP: begin
               neg_ff     <= t_ff[63];
               alu_cmd_ff <= mul_cmd(t_mag, urc_pkg::INCH_Q16);
               state_ff   <= S_MIMUL;
            end
            S_MIMUL: begin
               if (alu_rsp.done) begin
                  t_ff     <= p_rnd;
                  state_ff <= S_MIRND;
               end
            end
            S_MIRND: begin
               dist_ff   <= urc_pkg::sat24(t_ff >>> 16);
               status_ff <= urc_pkg::ST_MEASURED;
               state_ff  <= S_FINISH;
            end
            // Hold until the output register is free
            S_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_status_ff      <= status_ff;
                  rsp_distance_ff    <= dist_ff;
                  rsp_point_count_ff <= (cnt_wide > 32'd511) ? 9'd511 : cnt_wide[8:0];
                  rsp_slope_ff       <= slope_ff;
                  rsp_intercept_ff   <= offset_ff;
                  state_ff           <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_distance    = rsp_distance_ff;
   assign rsp_point_count = rsp_point_count_ff;
   assign rsp_slope       = rsp_slope_ff;
   assign rsp_intercept   = rsp_intercept_ff;

endmodule

// ===== rtl/urc_check.sv =====
// Port-level checker for the calibrated ranger, bound to the top level.
// Depends on urc_pkg.
module urc_check (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_status,
   input logic signed [23:0] rsp_distance,
   input logic [8:0]         rsp_point_count,
   input logic signed [23:0] rsp_slope,
   input logic signed [23:0] rsp_intercept
);

   // Reset drops any pending result
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One item at a time: busy right after a request transfer
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous item open");

   // Only a measure reports a distance
   a_dist_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != urc_pkg::ST_MEASURED) |-> rsp_distance == 24'sd0)
      else $error("nonzero distance on non-measure result");

   // Clear leaves an empty store and the identity fit
   a_clear_fit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == urc_pkg::ST_CLEARED) |->
      (rsp_point_count == 9'd0 && rsp_slope == urc_pkg::SLOPE_ONE &&
       rsp_intercept == 24'sd0))
      else $error("clear result does not show identity fit");

   // Stalled result stays valid and keeps its status and distance
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(rsp_status) && $stable(rsp_distance)))
      else $error("stalled result changed");

endmodule

bind ultrasonic_range_with_ls_calibration urc_check u_urc_check (.*);

// ===== sim/tb_ultrasonic_range_with_ls_calibration.sv =====
// Testbench for the ultrasonic ranger with least-squares calibration.
// Depends on urc_pkg and ultrasonic_range_with_ls_calibration; predicts every result.
`timescale 1ns / 1ps

module tb_ultrasonic_range_with_ls_calibration;

   localparam int MAX_PTS = 256;
   localparam longint CYCLE_LIMIT = 3000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [15:0]        csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = '0;
   logic [15:0]        req_echo_us = '0;
   logic [19:0]        req_known_dist = '0;
   logic               req_unit = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_status;
   logic signed [23:0] rsp_distance;
   logic [8:0]         rsp_point_count;
   logic signed [23:0] rsp_slope;
   logic signed [23:0] rsp_intercept;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [23:0] distance;
      logic [8:0]         point_count;
      logic signed [23:0] slope;
      logic signed [23:0] intercept;
   } range_result_type;

   range_result_type expected_results[$];
   int    error_count = 0;
   longint cycle_count = 0;
   int    rsp_wait = 0;

   // Predictor copy of the block's state
   logic [15:0]    hss;
   int unsigned    pts;
   longint         acc_x, acc_y, acc_xx, acc_xy;
   longint         cur_slope, cur_offset;

   ultrasonic_range_with_ls_calibration #(.MAX_POINTS(MAX_PTS)) dut (.*);

   always #4 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic longint floor_div_pow2(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-(v + 1)) >>> s) - 1;
   endfunction

   function automatic longint round_half_up(longint v, int s);
      return floor_div_pow2(v + (longint'(1) << (s - 1)), s);
   endfunction

   function automatic longint round_away(longint num, longint unsigned den);
      longint unsigned mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint slope_q16(longint num, longint unsigned den);
      longint unsigned mag, q, r, frac;
      longint v;
      mag = (num < 0) ? -num : num;
      q = mag / den;
      r = mag % den;
      frac = 0;
      if (q >= 256) q = 256;
      for (int i = 0; i < 17; i++) begin
         r = r << 1;
         frac = frac << 1;
         if (r >= den) begin
            r = r - den;
            frac = frac | 1;
         end
      end
      v = longint'((((q << 17) | frac) + 1) >> 1);
      return clamp24((num < 0) ? -v : v);
   endfunction

   task automatic clear_fit();
      pts = 0;
      acc_x = 0;
      acc_y = 0;
      acc_xx = 0;
      acc_xy = 0;
      cur_slope = 65536;
      cur_offset = 0;
   endtask

   // Work out the result of one item and advance the fit
   task automatic predict_range(logic [1:0] f, logic [15:0] echo, logic [19:0] known,
                                logic u);
      range_result_type r;
      longint raw, c, n, den;
      raw = (longint'(echo) * longint'(hss)) >>> 8;
      if (raw > 1048575) raw = 1048575;
      r = '0;
      if (f == urc_pkg::FUNC_CLEAR) begin
         clear_fit();
         r.status = urc_pkg::ST_CLEARED;
      end else if (f == urc_pkg::FUNC_CAL) begin
         if (pts >= MAX_PTS) begin
            r.status = urc_pkg::ST_FULL;
         end else begin
            pts++;
            acc_x += raw;
            acc_y += known;
            acc_xx += raw * raw;
            acc_xy += raw * longint'(known);
            n = pts;
            r.status = urc_pkg::ST_FIT;
            if (pts == 1) begin
               cur_slope = 65536;
               cur_offset = clamp24(longint'(known) - raw);
            end else begin
               den = n * acc_xx - acc_x * acc_x;
               if (den <= 0) begin
                  cur_slope = 65536;
                  cur_offset = clamp24(round_away(acc_y - acc_x, n));
                  r.status = urc_pkg::ST_DEGEN;
               end else begin
                  cur_slope = slope_q16(n * acc_xy - acc_x * acc_y, den);
                  cur_offset = clamp24(round_away(acc_y * 65536 - cur_slope * acc_x,
                                                  n * 65536));
               end
            end
         end
      end else begin
         c = round_half_up(cur_slope * raw, 16) + cur_offset;
         if (u) c = round_half_up(c * 25802, 16);
         r.distance = clamp24(c);
         r.status = urc_pkg::ST_MEASURED;
      end
      r.point_count = (pts > 511) ? 9'd511 : pts[8:0];
      r.slope = cur_slope[23:0];
      r.intercept = cur_offset[23:0];
      expected_results.push_back(r);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
   endtask

   // Send one item, then idle a random gap; the payload holds while stalled
   task automatic send_item(logic [1:0] f, logic [15:0] echo, logic [19:0] known,
                            logic u);
      int gap;
      gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 15);
      req_valid <= 1'b1;
      req_func <= f;
      req_echo_us <= echo;
      req_known_dist <= known;
      req_unit <= u;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_range(f, echo, known, u);
      req_valid <= 1'b0;
      @(posedge clock);
      repeat (gap) @(posedge clock);
   endtask

   // Wait for all results, then drain the block and write the register
   task automatic write_speed(logic [15:0] v);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      hss = v;
   endtask

   // Hold each result back for a drawn number of cycles
   always @(posedge clock) begin
      int w;
      w = rsp_wait;
      if (reset) begin
         w = $urandom_range(0, 15);
      end else if (rsp_valid && !rsp_stall) begin
         w = $urandom_range(0, 15);
      end else if (rsp_valid && w != 0) begin
         w = w - 1;
      end
      rsp_wait <= w;
      rsp_stall <= (w != 0);
   end

   // Compare each transfer with the oldest expectation
   always @(posedge clock) begin
      range_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_status, -1);
         end else begin
            e = expected_results.pop_front();
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_distance !== e.distance)
               report_mismatch("distance", rsp_distance, e.distance);
            if (rsp_point_count !== e.point_count)
               report_mismatch("point_count", rsp_point_count, e.point_count);
            if (rsp_slope !== e.slope) report_mismatch("slope", rsp_slope, e.slope);
            if (rsp_intercept !== e.intercept)
               report_mismatch("intercept", rsp_intercept, e.intercept);
         end
      end
   end

   task automatic test_directed();
      send_item(urc_pkg::FUNC_MEASURE, 16'd0, 20'd0, 1'b0);
      send_item(urc_pkg::FUNC_MEASURE, 16'hFFFF, 20'd0, 1'b1);
      send_item(2'd3, 16'd1234, 20'hFFFFF, 1'b0);
      send_item(urc_pkg::FUNC_CAL, 16'd1000, 20'hFFFFF, 1'b0);
      send_item(urc_pkg::FUNC_MEASURE, 16'd500, 20'd0, 1'b1);
      send_item(urc_pkg::FUNC_CAL, 16'd1000, 20'd0, 1'b0);
      send_item(urc_pkg::FUNC_CAL, 16'd3000, 20'd200000, 1'b0);
      send_item(urc_pkg::FUNC_MEASURE, 16'hFFFF, 20'd0, 1'b0);
      send_item(urc_pkg::FUNC_CAL, 16'd1, 20'hFFFFF, 1'b0);
      send_item(urc_pkg::FUNC_CAL, 16'd2, 20'd0, 1'b1);
      send_item(urc_pkg::FUNC_MEASURE, 16'hFFFF, 20'd0, 1'b1);
      send_item(urc_pkg::FUNC_CLEAR, 16'hFFFF, 20'hFFFFF, 1'b1);
      send_item(urc_pkg::FUNC_CAL, 16'd0, 20'd0, 1'b0);
      send_item(urc_pkg::FUNC_MEASURE, 16'd777, 20'd5, 1'b0);
   endtask

   // Fill the store past its limit with random points
   task automatic test_store_full();
      send_item(urc_pkg::FUNC_CLEAR, 16'd0, 20'd0, 1'b0);
      for (int i = 0; i < MAX_PTS + 3; i++) begin
         send_item(urc_pkg::FUNC_CAL, 16'($urandom), 20'($urandom), 1'($urandom));
      end
      send_item(urc_pkg::FUNC_MEASURE, 16'($urandom), 20'd0, 1'b1);
   endtask

   // Random mix of calibration points and measures, with some clears and spare codes
   task automatic test_random(int items);
      int k, base;
      logic [1:0] f;
      k = 0;
      base = $urandom_range(0, 65535);
      while (k < items) begin
         case ($urandom_range(0, 9))
            0: f = urc_pkg::FUNC_CLEAR;
            1, 2, 3, 4: f = urc_pkg::FUNC_CAL;
            9: f = 2'd3;
            default: f = urc_pkg::FUNC_MEASURE;
         endcase
         if (f == urc_pkg::FUNC_CAL && ($urandom & 1)) begin
            // echoes near a random base, sometimes repeated raw; known distances random
            send_item(f, 16'(base + $urandom_range(0, 4000)),
                      20'($urandom_range(0, 1048575)), 1'($urandom));
         end else begin
            send_item(f, 16'($urandom), 20'($urandom), 1'($urandom));
         end
         k++;
      end
   endtask

   initial begin
      hss = urc_pkg::HSS_RESET;
      clear_fit();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_speed(16'hFFFF);
      test_random(300);
      write_speed(16'd0);
      test_random(60);
      write_speed(16'd1);
      test_random(150);
      write_speed(16'd1114);
      test_store_full();
      write_speed(16'($urandom));
      test_random(400);
      write_speed(16'd40000);
      test_random(300);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/urc_pkg.sv
rtl/urc_alu.sv
rtl/ultrasonic_range_with_ls_calibration.sv
rtl/urc_check.sv
sim/tb_ultrasonic_range_with_ls_calibration.sv
